>>> design/ibec_pkg.sv
// shared constants and types for the imu bias estimate and compensate unit
package ibec_pkg;

    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 24;
    localparam int DATA_W     = 32;
    localparam int NUM_LANES  = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [30:0] GRAVITY_RESET = 31'd164528285;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_X  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_Y  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_Z  = 2'd3;

    // item actions
    localparam logic ACT_ACCUMULATE = 1'b0;
    localparam logic ACT_COMPENSATE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    // lane control from the sequencer
    typedef struct packed {
        logic start;
        logic accumulate;
        logic step;
    } lane_ctrl_t;

endpackage

>>> design/ibec_lane.sv
// one axis lane: running sum and a restoring divider for the mean
module ibec_lane #(
    parameter int COUNT_BITS = ibec_pkg::COUNT_BITS
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ibec_pkg::lane_ctrl_t         ctrl,
    input  logic signed [31:0]           sample,
    input  logic [COUNT_BITS-1:0]        divisor,
    output logic signed [31:0]           mean
);
    localparam int SUM_W = 32 + COUNT_BITS;
    localparam int MAG_W = SUM_W;

    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [MAG_W-1:0]        quo_reg, quo_next;
    logic [COUNT_BITS:0]     rem_reg, rem_next;
    logic                    neg_reg, neg_next;
    logic [MAG_W-1:0]        mag;
    logic [COUNT_BITS:0]     trial;
    logic [MAG_W-1:0]        q_signed;

    // sum update on request start when accumulating
    always_comb begin
        sum_next = sum_reg;
        if (ctrl.start && ctrl.accumulate) begin
            sum_next = sum_reg + SUM_W'(sample);
        end
    end

    // magnitude of the sum, taken after the update
    assign mag = sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);

    // one quotient bit a step
    assign trial = {rem_reg[COUNT_BITS-1:0], quo_reg[MAG_W-1]};

    always_comb begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (ctrl.start) begin
            quo_next = mag;
            rem_next = '0;
            neg_next = sum_next[SUM_W-1];
        end else if (ctrl.step) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end else begin
                rem_next = trial;
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // apply sign, zero when no samples
    assign q_signed = neg_reg ? MAG_W'(-quo_reg) : quo_reg;
    assign mean     = (divisor == '0) ? 32'sd0 : q_signed[31:0];
endmodule

>>> design/ibec_merge.sv
// output stage: bias removal with saturation or the plain mean, result register
module ibec_merge (
    input  logic                     aclk,
    input  logic                     load,
    input  logic                     compensate,
    input  logic [30:0]              gravity,
    input  logic signed [31:0]       rate [3],
    input  logic signed [31:0]       samp [ibec_pkg::NUM_LANES],
    input  logic signed [31:0]       mean [ibec_pkg::NUM_LANES],
    output logic signed [31:0]       result [ibec_pkg::NUM_LANES]
);
    logic signed [31:0] res_next [ibec_pkg::NUM_LANES];
    logic signed [34:0] bias [ibec_pkg::NUM_LANES];
    logic signed [34:0] diff [ibec_pkg::NUM_LANES];

    // bias per lane and saturated difference
    always_comb begin
        for (int i = 0; i < ibec_pkg::NUM_LANES; i++) begin
            bias[i] = 35'(mean[i]);
            if (i == 2) bias[i] = bias[i] + 35'({1'b0, gravity});
            if (i >= 3) bias[i] = bias[i] - 35'(rate[i-3]);
            diff[i] = 35'(samp[i]) - bias[i];
            if (!compensate) begin
                res_next[i] = mean[i];
            end else if (diff[i] > 35'sd2147483647) begin
                res_next[i] = 32'sh7fffffff;
            end else if (diff[i] < -35'sd2147483648) begin
                res_next[i] = 32'sh80000000;
            end else begin
                res_next[i] = diff[i][31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) result <= res_next;
    end
endmodule

>>> design/imu_bias_estimate_compensate_unit.sv
// top level of the imu bias estimate and compensate unit
//
// channel   | ports             | direction
// input     | s_valid / s_ready | in
// result    | m_valid / m_ready | out
// config    | cfg_we / cfg_idx  | in
//
// an item goes through a load step, one quotient bit per cycle in the six
// parallel divider lanes, a merge step into the result register, then the result.
// one item is in flight at a time; s_ready is low until the result is taken.
// reset is synchronous active low, clears sums, count and rate registers, sets gravity.
// a stalled m_ready holds the result and blocks the next request.
module imu_bias_estimate_compensate_unit #(
    parameter int COUNT_BITS = ibec_pkg::COUNT_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic signed [31:0]   s_accel_x,
    input  logic signed [31:0]   s_accel_y,
    input  logic signed [31:0]   s_accel_z,
    input  logic signed [31:0]   s_gyro_x,
    input  logic signed [31:0]   s_gyro_y,
    input  logic signed [31:0]   s_gyro_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_out_accel_x,
    output logic signed [31:0]   m_out_accel_y,
    output logic signed [31:0]   m_out_accel_z,
    output logic signed [31:0]   m_out_gyro_x,
    output logic signed [31:0]   m_out_gyro_y,
    output logic signed [31:0]   m_out_gyro_z,
    output logic                 m_count_full,
    input  logic                 cfg_we,
    input  logic [ibec_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [31:0]          cfg_data
);
    localparam int STEPS  = 32 + COUNT_BITS;
    localparam int STEP_W = $clog2(STEPS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    ibec_pkg::state_t state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   act_reg;
    logic [30:0]            gravity_reg;
    logic signed [31:0]     rate_reg [3];
    logic signed [31:0]     samp_reg [ibec_pkg::NUM_LANES];
    logic signed [31:0]     samp_in  [ibec_pkg::NUM_LANES];
    logic signed [31:0]     mean     [ibec_pkg::NUM_LANES];
    logic signed [31:0]     result   [ibec_pkg::NUM_LANES];
    ibec_pkg::lane_ctrl_t   ctrl;
    logic                   accept;
    logic                   do_acc;

    assign samp_in[0] = s_accel_x;
    assign samp_in[1] = s_accel_y;
    assign samp_in[2] = s_accel_z;
    assign samp_in[3] = s_gyro_x;
    assign samp_in[4] = s_gyro_y;
    assign samp_in[5] = s_gyro_z;

    assign s_ready = (state_reg == ibec_pkg::ST_IDLE);
    assign m_valid = (state_reg == ibec_pkg::ST_OUT);
    assign accept  = s_valid && s_ready;
    assign do_acc  = (s_action == ibec_pkg::ACT_ACCUMULATE) && (count_reg != COUNT_MAX);

    assign ctrl.start      = accept;
    assign ctrl.accumulate = do_acc;
    assign ctrl.step       = (state_reg == ibec_pkg::ST_DIV) && (step_reg != '0);

    // sequencer
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        unique case (state_reg)
            ibec_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = ibec_pkg::ST_DIV;
                    step_next  = STEP_W'(STEPS);
                    if (do_acc) count_next = count_reg + 1'b1;
                end
            end
            ibec_pkg::ST_DIV: begin
                if (step_reg != '0) begin
                    step_next = step_reg - 1'b1;
                end else begin
                    state_next = ibec_pkg::ST_OUT;
                end
            end
            ibec_pkg::ST_OUT: begin
                if (m_ready) state_next = ibec_pkg::ST_IDLE;
            end
            default: state_next = ibec_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ibec_pkg::ST_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            gravity_reg <= ibec_pkg::GRAVITY_RESET;
            rate_reg[0] <= '0;
            rate_reg[1] <= '0;
            rate_reg[2] <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            if (cfg_we) begin
                unique case (cfg_idx)
                    ibec_pkg::REG_GRAVITY: gravity_reg <= cfg_data[30:0];
                    ibec_pkg::REG_RATE_X:  rate_reg[0] <= cfg_data;
                    ibec_pkg::REG_RATE_Y:  rate_reg[1] <= cfg_data;
                    ibec_pkg::REG_RATE_Z:  rate_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // capture the request payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg  <= s_action;
            samp_reg <= samp_in;
        end
    end

    // six divider lanes
    for (genvar g = 0; g < ibec_pkg::NUM_LANES; g++) begin : g_lane
        ibec_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .sample  (samp_in[g]),
            .divisor (count_reg),
            .mean    (mean[g])
        );
    end

    ibec_merge u_merge (
        .aclk       (aclk),
        .load       ((state_reg == ibec_pkg::ST_DIV) && (step_reg == '0)),
        .compensate (act_reg == ibec_pkg::ACT_COMPENSATE),
        .gravity    (gravity_reg),
        .rate       (rate_reg),
        .samp       (samp_reg),
        .mean       (mean),
        .result     (result)
    );

    assign m_out_accel_x = result[0];
    assign m_out_accel_y = result[1];
    assign m_out_accel_z = result[2];
    assign m_out_gyro_x  = result[3];
    assign m_out_gyro_y  = result[4];
    assign m_out_gyro_z  = result[5];
    assign m_count_full  = (count_reg == COUNT_MAX);
endmodule

>>> tb/sv/imu_bias_estimate_compensate_unit_test.sv
// self-checking testbench for the imu bias estimate and compensate unit
`timescale 1ns / 100ps

module imu_bias_estimate_compensate_unit_test;
    import ibec_pkg::*;

    // sample count width of the block under test
    localparam int CNT_W = COUNT_BITS;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 2000000;

    typedef struct {
        logic               action;
        logic signed [31:0] accel [3];
        logic signed [31:0] gyro [3];
    } imu_sample_t;

    typedef struct {
        logic signed [31:0] accel [3];
        logic signed [31:0] gyro [3];
        logic               full;
    } imu_result_t;

    // bias model and queue of predicted results
    class bias_scoreboard;
        logic [30:0]        gravity;
        logic signed [31:0] rate [3];
        int unsigned        count;
        longint             accel_sum [3];
        longint             gyro_sum [3];
        imu_result_t        predicted [$];
        int                 mismatches;

        function new();
            gravity = GRAVITY_RESET;
            count = 0;
            mismatches = 0;
            for (int i = 0; i < 3; i++) begin
                rate[i] = 0;
                accel_sum[i] = 0;
                gyro_sum[i] = 0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                REG_GRAVITY: gravity = data[30:0];
                REG_RATE_X:  rate[0] = data;
                REG_RATE_Y:  rate[1] = data;
                REG_RATE_Z:  rate[2] = data;
                default: ;
            endcase
        endfunction

        function longint mean(longint sum);
            if (count == 0) return 0;
            return sum / longint'(count);
        endfunction

        function logic signed [31:0] clip32(longint v);
            if (v > 64'sd2147483647) return 32'sh7fffffff;
            if (v < -64'sd2147483648) return 32'sh80000000;
            return v[31:0];
        endfunction

        function bit full();
            return count == (1 << CNT_W) - 1;
        endfunction

        function int pending();
            return predicted.size();
        endfunction

        // note an accepted request and predict its result
        function void note_request(imu_sample_t s);
            imu_result_t r;
            longint abias, gbias;
            if (s.action == ACT_ACCUMULATE) begin
                if (!full()) begin
                    for (int i = 0; i < 3; i++) begin
                        accel_sum[i] += longint'(s.accel[i]);
                        gyro_sum[i] += longint'(s.gyro[i]);
                    end
                    count++;
                end
                for (int i = 0; i < 3; i++) begin
                    r.accel[i] = 32'(mean(accel_sum[i]));
                    r.gyro[i] = 32'(mean(gyro_sum[i]));
                end
            end else begin
                for (int i = 0; i < 3; i++) begin
                    abias = mean(accel_sum[i]);
                    if (i == 2) abias += longint'({1'b0, gravity});
                    gbias = mean(gyro_sum[i]) - longint'(rate[i]);
                    r.accel[i] = clip32(longint'(s.accel[i]) - abias);
                    r.gyro[i] = clip32(longint'(s.gyro[i]) - gbias);
                end
            end
            r.full = full();
            predicted.push_back(r);
        endfunction

        // compare a taken result with the oldest prediction
        function void check_result(imu_result_t act);
            imu_result_t exp_r;
            bit bad;
            if (predicted.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
                return;
            end
            exp_r = predicted.pop_front();
            bad = exp_r.full !== act.full;
            for (int i = 0; i < 3; i++)
                bad |= (exp_r.accel[i] !== act.accel[i]) || (exp_r.gyro[i] !== act.gyro[i]);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t: exp a=%h %h %h g=%h %h %h f=%b",
                              " act a=%h %h %h g=%h %h %h f=%b"},
                             $realtime, exp_r.accel[0], exp_r.accel[1], exp_r.accel[2],
                             exp_r.gyro[0], exp_r.gyro[1], exp_r.gyro[2], exp_r.full,
                             act.accel[0], act.accel[1], act.accel[2],
                             act.gyro[0], act.gyro[1], act.gyro[2], act.full);
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic s_action = ACT_ACCUMULATE;
    logic signed [31:0] s_accel_x = '0, s_accel_y = '0, s_accel_z = '0;
    logic signed [31:0] s_gyro_x = '0, s_gyro_y = '0, s_gyro_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_out_accel_x, m_out_accel_y, m_out_accel_z;
    logic signed [31:0] m_out_gyro_x, m_out_gyro_y, m_out_gyro_z;
    logic m_count_full;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = REG_GRAVITY;
    logic [31:0] cfg_data = '0;

    bias_scoreboard sb = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int unsigned cycles = 0;

    always #2 aclk = ~aclk;

    imu_bias_estimate_compensate_unit #(.COUNT_BITS(CNT_W)) dut (.*);

    // timeout guard
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result monitor
    always @(posedge aclk) begin
        imu_result_t r;
        if (aresetn && m_valid && m_ready) begin
            r.accel = '{m_out_accel_x, m_out_accel_y, m_out_accel_z};
            r.gyro = '{m_out_gyro_x, m_out_gyro_y, m_out_gyro_z};
            r.full = m_count_full;
            sb.check_result(r);
        end
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                m_ready = 1'b1;
            end else begin
                m_ready = quiet || ($urandom_range(99) >= 7);
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_idx = idx;
        cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (CNT_W + 40) @(posedge aclk);
    endtask

    // present one request and wait for it to be taken
    task automatic send(imu_sample_t s);
        if (!quiet && $urandom_range(99) < 7) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_action = s.action;
        {s_accel_x, s_accel_y, s_accel_z} = {s.accel[0], s.accel[1], s.accel[2]};
        {s_gyro_x, s_gyro_y, s_gyro_z} = {s.gyro[0], s.gyro[1], s.gyro[2]};
        do @(posedge aclk); while (!s_ready);
        sb.note_request(s);
        @(negedge aclk);
    endtask

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return $signed($urandom_range(200)) - 100;
            3: return 32'sd164528285 + $signed($urandom_range(2000)) - 1000;
            default: return $urandom;
        endcase
    endfunction

    function automatic imu_sample_t make_sample(logic act);
        imu_sample_t s;
        s.action = act;
        for (int i = 0; i < 3; i++) begin
            s.accel[i] = pick_value();
            s.gyro[i] = pick_value();
        end
        return s;
    endfunction

    function automatic imu_sample_t uniform_sample(logic act, logic signed [31:0] v);
        imu_sample_t s;
        s.action = act;
        s.accel = '{v, v, v};
        s.gyro = '{v, v, v};
        return s;
    endfunction

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++)
            send(make_sample($urandom_range(99) < 40 ? ACT_COMPENSATE : ACT_ACCUMULATE));
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // directed: empty means, extremes, saturation of compensation
        send(uniform_sample(ACT_COMPENSATE, 32'sh0));
        send(uniform_sample(ACT_COMPENSATE, 32'sh80000000));
        send(uniform_sample(ACT_COMPENSATE, 32'sh7fffffff));
        send(uniform_sample(ACT_ACCUMULATE, 32'sh7fffffff));
        send(uniform_sample(ACT_ACCUMULATE, 32'sh7fffffff));
        send(uniform_sample(ACT_COMPENSATE, 32'sh80000000));
        send(uniform_sample(ACT_ACCUMULATE, 32'sh80000000));
        send(uniform_sample(ACT_ACCUMULATE, 32'sh80000000));
        send(uniform_sample(ACT_ACCUMULATE, 32'sh80000000));
        send(uniform_sample(ACT_COMPENSATE, 32'sh7fffffff));
        send(uniform_sample(ACT_ACCUMULATE, -32'sd7));
        send(uniform_sample(ACT_COMPENSATE, 32'sh0));
        for (int k = 0; k < 8; k++)
            send(make_sample(k[0]));
        s_valid = 1'b0;
        wait_drained();

        // extreme low registers, rate y zero
        cfg_write(REG_GRAVITY, 32'h8000_0000);
        cfg_write(REG_RATE_X, 32'h8000_0000);
        cfg_write(REG_RATE_Y, 32'h0);
        cfg_write(REG_RATE_Z, 32'h8000_0000);
        random_phase(250);
        s_valid = 1'b0;
        wait_drained();

        // extreme high registers, rate y lowest, with a long receiver hold-off
        cfg_write(REG_GRAVITY, 32'h7fff_ffff);
        cfg_write(REG_RATE_X, 32'h7fff_ffff);
        cfg_write(REG_RATE_Y, 32'h8000_0000);
        cfg_write(REG_RATE_Z, 32'h7fff_ffff);
        hold_req = 1'b1;
        random_phase(250);
        s_valid = 1'b0;
        wait_drained();

        // random registers, no idling on either side
        quiet = 1'b1;
        cfg_write(REG_GRAVITY, $urandom);
        cfg_write(REG_RATE_X, $urandom);
        cfg_write(REG_RATE_Y, $urandom);
        cfg_write(REG_RATE_Z, $urandom);
        random_phase(250);
        s_valid = 1'b0;
        wait_drained();
        quiet = 1'b0;

        // typical small earth rate and gravity
        cfg_write(REG_GRAVITY, 32'd164528285);
        cfg_write(REG_RATE_X, $urandom_range(2000));
        cfg_write(REG_RATE_Y, -$urandom_range(2000));
        cfg_write(REG_RATE_Z, $urandom_range(2000));
        random_phase(430);

        // a final short mix
        random_phase(40);
        s_valid = 1'b0;
        wait_drained();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
